>>> rtl/core/rsc_pkg.sv
package rsc_pkg;

	// Default sizes of the converter.
	localparam int MAX_RADIX_DEF = 16;
	localparam int ACC_WIDTH_DEF = 32;

	// Quotient bits the digit divider retires per cycle.
	localparam int DIV_STEP = 8;

	localparam int CFG_RADIX_W = 5;
	localparam int CFG_WORD_W  = 64;
	localparam int CFG_IDX_W   = 3;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FROM_RADIX = 3'd0,
		CFG_FROM_LOW   = 3'd1,
		CFG_FROM_HIGH  = 3'd2,
		CFG_TO_RADIX   = 3'd3,
		CFG_TO_LOW     = 3'd4,
		CFG_TO_HIGH    = 3'd5
	} cfg_index_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ALPHABET = 2'd1,
		ST_DIGIT    = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef struct packed {
		logic [CFG_RADIX_W-1:0] from_radix;
		logic [CFG_WORD_W-1:0]  from_low;
		logic [CFG_WORD_W-1:0]  from_high;
		logic [CFG_RADIX_W-1:0] to_radix;
		logic [CFG_WORD_W-1:0]  to_low;
		logic [CFG_WORD_W-1:0]  to_high;
	} cfg_regs_t;

	// Microprogram.
	localparam int PC_W = 4;

	typedef enum logic [3:0] {
		A_NOP        = 4'd0,
		A_FETCH      = 4'd1,
		A_CLASSIFY   = 4'd2,
		A_MARK       = 4'd3,
		A_ACCUM      = 4'd4,
		A_STATUS     = 4'd5,
		A_DIV_INIT   = 4'd6,
		A_DIV_STEP   = 4'd7,
		A_STORE      = 4'd8,
		A_EMIT_MINUS = 4'd9,
		A_READ       = 4'd10,
		A_EMIT_DIGIT = 4'd11,
		A_CLEAR      = 4'd12,
		A_EMIT_ERR   = 4'd13
	} action_t;

	typedef enum logic [3:0] {
		C_NEXT        = 4'd0,
		C_ALWAYS      = 4'd1,
		C_NO_INPUT    = 4'd2,
		C_SKIP        = 4'd3,
		C_NOT_LAST    = 4'd4,
		C_ERR         = 4'd5,
		C_DIV_MORE    = 4'd6,
		C_Q_NONZERO   = 4'd7,
		C_MORE_DIGITS = 4'd8
	} cond_t;

	typedef struct packed {
		action_t         action;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ctrl_word_t;

	typedef struct packed {
		logic in_fire;
		logic skip;
		logic last;
		logic err;
		logic div_more;
		logic q_nonzero;
		logic more_digits;
		logic hold;
	} dp_flags_t;

	localparam logic [PC_W-1:0] PC_FETCH    = 4'd0;
	localparam logic [PC_W-1:0] PC_CLASSIFY = 4'd1;
	localparam logic [PC_W-1:0] PC_MARK     = 4'd2;
	localparam logic [PC_W-1:0] PC_ACCUM    = 4'd3;
	localparam logic [PC_W-1:0] PC_CHKLAST  = 4'd4;
	localparam logic [PC_W-1:0] PC_ERRCHK   = 4'd5;
	localparam logic [PC_W-1:0] PC_DIVINIT  = 4'd6;
	localparam logic [PC_W-1:0] PC_DIVSTEP  = 4'd7;
	localparam logic [PC_W-1:0] PC_STORE    = 4'd8;
	localparam logic [PC_W-1:0] PC_MINUS    = 4'd9;
	localparam logic [PC_W-1:0] PC_READ     = 4'd10;
	localparam logic [PC_W-1:0] PC_DIGIT    = 4'd11;
	localparam logic [PC_W-1:0] PC_DONE     = 4'd12;
	localparam logic [PC_W-1:0] PC_ERR      = 4'd13;

	function automatic logic [7:0] symbol_at(input logic [CFG_WORD_W-1:0] lo,
			input logic [CFG_WORD_W-1:0] hi, input logic [3:0] idx);
		logic [2*CFG_WORD_W-1:0] both;
		both = {hi, lo};
		return both[{idx, 3'b000} +: 8];
	endfunction

endpackage

>>> rtl/core/rsc_seq.sv
module rsc_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  rsc_pkg::dp_flags_t flags,
	output rsc_pkg::ctrl_word_t ctrl
);
	import rsc_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic            take;

	function automatic ctrl_word_t cw(input action_t a, input cond_t c,
			input logic [PC_W-1:0] t);
		ctrl_word_t w;
		w.action = a;
		w.cond   = c;
		w.target = t;
		return w;
	endfunction

	function automatic ctrl_word_t rom_word(input logic [PC_W-1:0] a);
		ctrl_word_t w;
		case (a)
			PC_FETCH:    w = cw(A_FETCH,      C_NO_INPUT,    PC_FETCH);
			PC_CLASSIFY: w = cw(A_CLASSIFY,   C_SKIP,        PC_CHKLAST);
			PC_MARK:     w = cw(A_MARK,       C_NEXT,        PC_FETCH);
			PC_ACCUM:    w = cw(A_ACCUM,      C_NEXT,        PC_FETCH);
			PC_CHKLAST:  w = cw(A_STATUS,     C_NOT_LAST,    PC_FETCH);
			PC_ERRCHK:   w = cw(A_NOP,        C_ERR,         PC_ERR);
			PC_DIVINIT:  w = cw(A_DIV_INIT,   C_NEXT,        PC_FETCH);
			PC_DIVSTEP:  w = cw(A_DIV_STEP,   C_DIV_MORE,    PC_DIVSTEP);
			PC_STORE:    w = cw(A_STORE,      C_Q_NONZERO,   PC_DIVSTEP);
			PC_MINUS:    w = cw(A_EMIT_MINUS, C_NEXT,        PC_FETCH);
			PC_READ:     w = cw(A_READ,       C_NEXT,        PC_FETCH);
			PC_DIGIT:    w = cw(A_EMIT_DIGIT, C_MORE_DIGITS, PC_READ);
			PC_DONE:     w = cw(A_CLEAR,      C_ALWAYS,      PC_FETCH);
			PC_ERR:      w = cw(A_EMIT_ERR,   C_ALWAYS,      PC_DONE);
			default:     w = cw(A_NOP,        C_ALWAYS,      PC_FETCH);
		endcase
		return w;
	endfunction

	assign ctrl = rom_word(pc_q);

	always_comb begin
		case (ctrl.cond)
			C_NEXT:        take = 1'b0;
			C_ALWAYS:      take = 1'b1;
			C_NO_INPUT:    take = !flags.in_fire;
			C_SKIP:        take = flags.skip;
			C_NOT_LAST:    take = !flags.last;
			C_ERR:         take = flags.err;
			C_DIV_MORE:    take = flags.div_more;
			C_Q_NONZERO:   take = flags.q_nonzero;
			C_MORE_DIGITS: take = flags.more_digits;
			default:       take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_FETCH;
		end else if (!flags.hold) begin
			pc_q <= take ? ctrl.target : pc_q + 4'd1;
		end
	end

endmodule

>>> rtl/core/rsc_datapath.sv
module rsc_datapath #(
	parameter int MAX_RADIX = rsc_pkg::MAX_RADIX_DEF,
	parameter int ACC_WIDTH = rsc_pkg::ACC_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rsc_pkg::ctrl_word_t ctrl,
	input  rsc_pkg::cfg_regs_t  cfg,
	input  logic                in_valid,
	input  logic [7:0]          in_char,
	input  logic                in_last,
	input  logic                out_stall,
	output logic                out_valid,
	output logic [7:0]          out_char,
	output logic                out_last,
	output logic [1:0]          status,
	output rsc_pkg::dp_flags_t  flags
);
	import rsc_pkg::*;

	localparam int RAD_W   = $clog2(MAX_RADIX + 1);
	localparam int DIG_W   = $clog2(MAX_RADIX);
	localparam int PROD_W  = ACC_WIDTH + RAD_W;
	localparam int NSTEP   = (ACC_WIDTH + DIV_STEP - 1) / DIV_STEP;
	localparam int PAD_W   = NSTEP * DIV_STEP;
	localparam int CNT_W   = (NSTEP > 1) ? $clog2(NSTEP) : 1;
	localparam int SLOTS   = ACC_WIDTH + 1;
	localparam int ADDR_W  = $clog2(SLOTS);

	// Number state.
	logic [ACC_WIDTH-1:0] acc_q;
	logic                 neg_q;
	logic                 first_q;
	logic                 bad_q;
	logic                 ovf_q;

	logic [7:0]           char_q;
	logic                 last_q;
	logic [DIG_W-1:0]     digit_q;
	logic                 found_q;
	logic [PROD_W-1:0]    prod_q;
	status_t              status_q;
	logic                 alph_ok_q;

	// Digit divider and store.
	logic [PAD_W-1:0]     div_q;
	logic [DIG_W-1:0]     rem_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [RAD_W-1:0]     tr_q;
	logic                 minus_q;
	logic [ADDR_W-1:0]    ndig_q;
	logic [7:0]           mem [SLOTS];
	logic [7:0]           rd_data_q;

	logic                 out_valid_q;
	logic [7:0]           out_char_q;
	logic                 out_last_q;
	status_t              out_status_q;

	logic                 in_fire;
	logic                 is_sign;
	logic [RAD_W-1:0]     fr;
	logic [DIG_W-1:0]     look_digit;
	logic                 look_found;
	logic [PROD_W-1:0]    lim;
	logic [DIG_W-1:0]     rem_next;
	logic [DIV_STEP-1:0]  qbits;
	logic [DIG_W:0]       trial;
	logic                 emit_req;
	logic                 go;

	function automatic logic alph_ok(input logic [CFG_RADIX_W-1:0] radix,
			input logic [CFG_WORD_W-1:0] lo, input logic [CFG_WORD_W-1:0] hi);
		logic       ok;
		logic [7:0] s;
		ok = (radix >= 5'd2) && (radix <= 5'(MAX_RADIX));
		for (int i = 0; i < MAX_RADIX; i++) begin
			if (5'(i) < radix) begin
				s = symbol_at(lo, hi, 4'(i));
				if (s == CH_NUL || s == CH_PLUS || s == CH_MINUS || s == CH_SPACE)
					ok = 1'b0;
				for (int j = 0; j < i; j++) begin
					if (symbol_at(lo, hi, 4'(j)) == s)
						ok = 1'b0;
				end
			end
		end
		return ok;
	endfunction

	assign in_fire = in_valid && (ctrl.action == A_FETCH);
	assign is_sign = (char_q == CH_PLUS) || (char_q == CH_MINUS);

	assign fr = (cfg.from_radix > 5'(MAX_RADIX)) ? RAD_W'(MAX_RADIX)
		: cfg.from_radix[RAD_W-1:0];

	// First match wins, so scan from the top and let lower indices override.
	always_comb begin
		look_digit = '0;
		look_found = 1'b0;
		for (int i = MAX_RADIX - 1; i >= 0; i--) begin
			if (RAD_W'(i) < fr && symbol_at(cfg.from_low, cfg.from_high, 4'(i)) == char_q) begin
				look_digit = DIG_W'(i);
				look_found = 1'b1;
			end
		end
	end

	// Largest magnitude: 2^(W-1) when negative, 2^(W-1)-1 otherwise.
	assign lim = PROD_W'({neg_q, {(ACC_WIDTH-1){~neg_q}}});

	// Restoring division, DIV_STEP quotient bits per cycle, remainder stays narrow.
	always_comb begin
		rem_next = rem_q;
		qbits    = '0;
		trial    = '0;
		for (int k = 0; k < DIV_STEP; k++) begin
			trial = {rem_next, div_q[PAD_W-1-k]};
			if (trial >= (DIG_W+1)'(tr_q)) begin
				rem_next = DIG_W'(trial - (DIG_W+1)'(tr_q));
				qbits[DIV_STEP-1-k] = 1'b1;
			end else begin
				rem_next = trial[DIG_W-1:0];
			end
		end
	end

	assign emit_req = (ctrl.action == A_EMIT_ERR) || (ctrl.action == A_EMIT_DIGIT)
		|| (ctrl.action == A_EMIT_MINUS && minus_q);
	assign go = !(emit_req && out_valid_q && out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			neg_q   <= 1'b0;
			first_q <= 1'b1;
			bad_q   <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			case (ctrl.action)
				A_CLASSIFY: begin
					first_q <= 1'b0;
					if (first_q && is_sign)
						neg_q <= (char_q == CH_MINUS);
				end
				A_MARK: begin
					if (!found_q)
						bad_q <= 1'b1;
				end
				A_ACCUM: begin
					if (found_q) begin
						if (prod_q > lim)
							ovf_q <= 1'b1;
						else
							acc_q <= prod_q[ACC_WIDTH-1:0];
					end
				end
				A_CLEAR: begin
					acc_q   <= '0;
					neg_q   <= 1'b0;
					first_q <= 1'b1;
					bad_q   <= 1'b0;
					ovf_q   <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		alph_ok_q <= alph_ok(cfg.from_radix, cfg.from_low, cfg.from_high)
			&& alph_ok(cfg.to_radix, cfg.to_low, cfg.to_high);
		case (ctrl.action)
			A_FETCH: begin
				if (in_fire) begin
					char_q <= in_char;
					last_q <= in_last;
				end
			end
			A_CLASSIFY: begin
				digit_q <= look_digit;
				found_q <= look_found;
			end
			A_MARK: begin
				prod_q <= PROD_W'(acc_q) * PROD_W'(fr) + PROD_W'(digit_q);
			end
			A_STATUS: begin
				if (!alph_ok_q)
					status_q <= ST_ALPHABET;
				else if (bad_q)
					status_q <= ST_DIGIT;
				else if (ovf_q)
					status_q <= ST_OVERFLOW;
				else
					status_q <= ST_OK;
			end
			A_DIV_INIT: begin
				div_q   <= PAD_W'(acc_q);
				rem_q   <= '0;
				cnt_q   <= '0;
				ndig_q  <= '0;
				tr_q    <= cfg.to_radix[RAD_W-1:0];
				minus_q <= neg_q && (acc_q != '0);
			end
			A_DIV_STEP: begin
				div_q <= (div_q << DIV_STEP) | PAD_W'(qbits);
				rem_q <= rem_next;
				cnt_q <= cnt_q + 1'b1;
			end
			A_STORE: begin
				mem[ndig_q] <= symbol_at(cfg.to_low, cfg.to_high, 4'(rem_q));
				ndig_q      <= ndig_q + 1'b1;
				rem_q       <= '0;
				cnt_q       <= '0;
			end
			A_READ: begin
				rd_data_q <= mem[ndig_q - 1'b1];
				ndig_q    <= ndig_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Output register: a result may wait here while the next request is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_req && go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_req && go) begin
			case (ctrl.action)
				A_EMIT_MINUS: begin
					out_char_q   <= CH_MINUS;
					out_last_q   <= 1'b0;
					out_status_q <= ST_OK;
				end
				A_EMIT_DIGIT: begin
					out_char_q   <= rd_data_q;
					out_last_q   <= (ndig_q == '0);
					out_status_q <= ST_OK;
				end
				default: begin
					out_char_q   <= CH_NUL;
					out_last_q   <= 1'b1;
					out_status_q <= status_q;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;
	assign status    = out_status_q;

	assign flags.in_fire     = in_fire;
	assign flags.skip        = (first_q && is_sign) || bad_q || ovf_q;
	assign flags.last        = last_q;
	assign flags.err         = (status_q != ST_OK);
	assign flags.div_more    = (cnt_q != CNT_W'(NSTEP - 1));
	assign flags.q_nonzero   = (div_q != '0);
	assign flags.more_digits = (ndig_q != '0);
	assign flags.hold        = !go;

endmodule

>>> rtl/core/radix_string_converter_unit.sv
// Converts a number given one character per request, in the source alphabet with an optional
// leading sign, into the same value in the destination alphabet, most significant digit first
// with a leading '-' for negative values; a bad alphabet, a foreign character or overflow of
// the ACC_WIDTH-bit signed range yields one result with out_char zero and an error status.
// A small microprogram steps the shared datapath one control word per cycle unless a result
// waiting at the output stalls it. A character that is not the last passes fetch, lookup,
// multiply-add, range check and end test, or only fetch, lookup and end test if it is the
// sign or follows an error. The last character adds an error check; an error result is
// then emitted, plus any stall at the output. Otherwise the divider is loaded and the value
// is divided by the destination radix once per output digit; the divider retires 8 quotient
// bits a cycle, and each digit ends in a store step. The optional minus sign step follows,
// spent even when there is no sign, then each digit takes a read and an emit step, plus any
// stall at the output. A last step clears the number state, then the next request is taken.
// Configuration must be written only while idle; the block itself does not enforce it.
module radix_string_converter_unit #(
	parameter int MAX_RADIX = rsc_pkg::MAX_RADIX_DEF,
	parameter int ACC_WIDTH = rsc_pkg::ACC_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      in_char,
	input  logic                            in_last,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      out_char,
	output logic                            out_last,
	output logic [1:0]                      status,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rsc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rsc_pkg::CFG_WORD_W-1:0]  cfg_data
);
	import rsc_pkg::*;

	cfg_regs_t  cfg_q;
	ctrl_word_t ctrl;
	dp_flags_t  flags;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.from_radix <= 5'd2;
			cfg_q.from_low   <= '0;
			cfg_q.from_high  <= '0;
			cfg_q.to_radix   <= 5'd2;
			cfg_q.to_low     <= '0;
			cfg_q.to_high    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FROM_RADIX: cfg_q.from_radix <= cfg_data[CFG_RADIX_W-1:0];
				CFG_FROM_LOW:   cfg_q.from_low   <= cfg_data;
				CFG_FROM_HIGH:  cfg_q.from_high  <= cfg_data;
				CFG_TO_RADIX:   cfg_q.to_radix   <= cfg_data[CFG_RADIX_W-1:0];
				CFG_TO_LOW:     cfg_q.to_low     <= cfg_data;
				CFG_TO_HIGH:    cfg_q.to_high    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign in_stall = (ctrl.action != A_FETCH);

	rsc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	rsc_datapath #(
		.MAX_RADIX (MAX_RADIX),
		.ACC_WIDTH (ACC_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_char   (in_char),
		.in_last   (in_last),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_char  (out_char),
		.out_last  (out_last),
		.status    (status),
		.flags     (flags)
	);

endmodule

>>> rtl/core/rsc_checker.sv
module rsc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  out_char,
	input logic        out_last,
	input logic [1:0]  status
);
	import rsc_pkg::*;

	// A stalled result must hold its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(out_last)
			&& $stable(status))
		else $error("stalled result changed");

	// Error results always close the number.
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> out_last)
		else $error("error result not marked last");

	// Error results carry no character.
	a_err_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> out_char == CH_NUL)
		else $error("error result carries a character");

	// One character is worked on at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken on consecutive cycles");

endmodule

bind radix_string_converter_unit rsc_checker u_rsc_checker (.*);

>>> sim/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rsc_pkg::*;

	localparam int ACC_W = ACC_WIDTH_DEF;
	localparam int MAX_R = MAX_RADIX_DEF;
	localparam int DIGIT_SLOTS = ACC_W + 1;
	localparam int IDLE_GAP = 20;
	localparam int CYCLE_LIMIT = 400000;

	localparam logic [63:0] HEX_LO = 64'h3736_3534_3332_3130;
	localparam logic [63:0] HEX_HI = 64'h4645_4443_4241_3938;
	localparam logic [63:0] DEC_HI = 64'h0000_0000_0000_3938;
	localparam logic [63:0] BIN_LO = 64'h0000_0000_0000_3130;

	typedef struct {
		logic [7:0] ch;
		logic       last;
		status_t    st;
	} conv_char_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  in_char = 8'h00;
	logic        in_last = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_char;
	logic        out_last;
	logic [1:0]  status;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_FROM_RADIX;
	logic [CFG_WORD_W-1:0] cfg_data = '0;

	// Mirror of the converter's registers and number state.
	logic [4:0]  src_radix = 5'd2;
	logic [63:0] src_lo = '0;
	logic [63:0] src_hi = '0;
	logic [4:0]  dst_radix = 5'd2;
	logic [63:0] dst_lo = '0;
	logic [63:0] dst_hi = '0;
	logic [63:0] value_mag = '0;
	bit          neg_flag = 1'b0;
	bit          first_char = 1'b1;
	bit          bad_seen = 1'b0;
	bit          ovf_seen = 1'b0;

	conv_char_t  expected_out[$];
	int unsigned send_pct = 11;
	int unsigned recv_pct = 55;
	int unsigned sent_chars = 0;
	int unsigned fail_count = 0;
	int unsigned cycles = 0;

	radix_string_converter_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_char   (in_char),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_char  (out_char),
		.out_last  (out_last),
		.status    (status),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("radix_string_converter_unit regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_pct);
	end

	function automatic logic [7:0] sym_of(logic [63:0] lo, logic [63:0] hi, int unsigned idx);
		return (idx < 8) ? lo[idx*8 +: 8] : hi[(idx-8)*8 +: 8];
	endfunction

	function automatic bit alphabet_valid(logic [4:0] radix, logic [63:0] lo, logic [63:0] hi);
		logic [7:0] s;
		if (radix < 2 || radix > MAX_R)
			return 1'b0;
		for (int i = 0; i < radix; i++) begin
			s = sym_of(lo, hi, i);
			if (s == CH_NUL || s == CH_PLUS || s == CH_MINUS || s == CH_SPACE)
				return 1'b0;
			for (int j = 0; j < i; j++)
				if (sym_of(lo, hi, j) == s)
					return 1'b0;
		end
		return 1'b1;
	endfunction

	// Advances the number state by one accepted character and queues the text it produces.
	function automatic void take_char(logic [7:0] c, logic last);
		int unsigned r;
		int unsigned digit;
		int unsigned n;
		bit          found;
		logic [63:0] lim;
		logic [63:0] m;
		status_t     st;
		logic [7:0]  digits [DIGIT_SLOTS];
		if (first_char && (c == CH_PLUS || c == CH_MINUS)) begin
			neg_flag = (c == CH_MINUS);
			first_char = 1'b0;
		end else begin
			first_char = 1'b0;
			if (!bad_seen && !ovf_seen) begin
				r = (src_radix > MAX_R) ? MAX_R : src_radix;
				found = 1'b0;
				digit = 0;
				for (int i = 0; i < r && !found; i++) begin
					if (sym_of(src_lo, src_hi, i) == c) begin
						digit = i;
						found = 1'b1;
					end
				end
				if (!found) begin
					bad_seen = 1'b1;
				end else begin
					// A negative number may reach one more than the largest positive value.
					lim = (64'd1 << (ACC_W - 1)) - (neg_flag ? 64'd0 : 64'd1);
					if (value_mag > (lim - digit) / r)
						ovf_seen = 1'b1;
					else
						value_mag = value_mag * r + digit;
				end
			end
		end
		if (!last)
			return;
		if (!alphabet_valid(src_radix, src_lo, src_hi) ||
				!alphabet_valid(dst_radix, dst_lo, dst_hi))
			st = ST_ALPHABET;
		else if (bad_seen)
			st = ST_DIGIT;
		else if (ovf_seen)
			st = ST_OVERFLOW;
		else
			st = ST_OK;
		if (st != ST_OK) begin
			expected_out.push_back('{CH_NUL, 1'b1, st});
		end else begin
			m = value_mag;
			n = 0;
			do begin
				digits[n] = sym_of(dst_lo, dst_hi, 32'(m % dst_radix));
				n++;
				m = m / dst_radix;
			end while (m != 0 && n < DIGIT_SLOTS);
			// Zero keeps no sign even when it was written with a minus.
			if (neg_flag && value_mag != 0)
				expected_out.push_back('{CH_MINUS, 1'b0, ST_OK});
			while (n > 0) begin
				n--;
				expected_out.push_back('{digits[n], n == 0, ST_OK});
			end
		end
		value_mag = '0;
		neg_flag = 1'b0;
		first_char = 1'b1;
		bad_seen = 1'b0;
		ovf_seen = 1'b0;
	endfunction

	always @(negedge clk) begin
		conv_char_t exp_char;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_out.size() == 0) begin
				$display("%0t: unexpected result: char %h last %b status %0d",
					$time, out_char, out_last, status);
				fail_count++;
			end else begin
				exp_char = expected_out.pop_front();
				if (out_char !== exp_char.ch) begin
					$display("%0t: out_char expected %h, got %h", $time, exp_char.ch, out_char);
					fail_count++;
				end
				if (out_last !== exp_char.last) begin
					$display("%0t: out_last expected %b, got %b", $time, exp_char.last, out_last);
					fail_count++;
				end
				if (status !== exp_char.st) begin
					$display("%0t: status expected %0d, got %0d", $time, exp_char.st, status);
					fail_count++;
				end
			end
		end
	end

	task automatic send_char(logic [7:0] c, logic last);
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_char <= c;
		in_last <= last;
		do @(negedge clk); while (in_stall !== 1'b0);
		@(posedge clk);
		take_char(c, last);
		sent_chars++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_out.size() != 0)
			@(posedge clk);
		repeat (IDLE_GAP) @(posedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(negedge clk); while (cfg_ready !== 1'b1);
		@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_FROM_RADIX: src_radix = data[4:0];
			CFG_FROM_LOW:   src_lo = data;
			CFG_FROM_HIGH:  src_hi = data;
			CFG_TO_RADIX:   dst_radix = data[4:0];
			CFG_TO_LOW:     dst_lo = data;
			CFG_TO_HIGH:    dst_hi = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_alphabets(logic [4:0] fr, logic [63:0] flo, logic [63:0] fhi,
			logic [4:0] tr, logic [63:0] tlo, logic [63:0] thi);
		logic [63:0] word;
		wait_idle();
		// Upper bits of a radix write carry noise; only the low five bits count.
		word = {$urandom, $urandom};
		word[4:0] = fr;
		write_reg(CFG_FROM_RADIX, word);
		write_reg(CFG_FROM_LOW, flo);
		write_reg(CFG_FROM_HIGH, fhi);
		word = {$urandom, $urandom};
		word[4:0] = tr;
		write_reg(CFG_TO_RADIX, word);
		write_reg(CFG_TO_LOW, tlo);
		write_reg(CFG_TO_HIGH, thi);
	endtask

	function automatic int unsigned pick_radix();
		case ($urandom_range(9))
			0: return 2;
			1: return MAX_R;
			default: return $urandom_range(MAX_R, 2);
		endcase
	endfunction

	// Distinct legal symbols below the radix, arbitrary bytes above it.
	function automatic void make_alphabet(int unsigned radix, output logic [63:0] lo,
			output logic [63:0] hi);
		logic [127:0] both;
		logic [7:0]   s;
		bit           clash;
		both = {$urandom, $urandom, $urandom, $urandom};
		for (int i = 0; i < radix; i++) begin
			do begin
				s = 8'($urandom_range(255, 1));
				clash = (s == CH_PLUS || s == CH_MINUS || s == CH_SPACE);
				for (int j = 0; j < i; j++)
					if (both[j*8 +: 8] == s)
						clash = 1'b1;
			end while (clash);
			both[i*8 +: 8] = s;
		end
		lo = both[63:0];
		hi = both[127:64];
	endfunction

	function automatic logic [7:0] src_digit();
		int unsigned r;
		r = (src_radix > MAX_R) ? MAX_R : src_radix;
		if (r == 0)
			return 8'($urandom_range(255, 0));
		return sym_of(src_lo, src_hi, $urandom_range(r - 1, 0));
	endfunction

	task automatic random_config();
		int unsigned fr;
		int unsigned tr;
		logic [63:0] flo;
		logic [63:0] fhi;
		logic [63:0] tlo;
		logic [63:0] thi;
		logic [7:0]  bad_sym;
		fr = pick_radix();
		tr = pick_radix();
		make_alphabet(fr, flo, fhi);
		make_alphabet(tr, tlo, thi);
		if ($urandom_range(7) == 0) begin
			case ($urandom_range(3))
				0: bad_sym = CH_NUL;
				1: bad_sym = CH_PLUS;
				2: bad_sym = CH_MINUS;
				default: bad_sym = CH_SPACE;
			endcase
			case ($urandom_range(3))
				0: fr = $urandom_range(1) ? $urandom_range(1, 0) : $urandom_range(31, 17);
				1: tr = $urandom_range(1) ? $urandom_range(1, 0) : $urandom_range(31, 17);
				2: flo[8*$urandom_range((fr > 8) ? 7 : fr - 1, 0) +: 8] = bad_sym;
				default: tlo[15:8] = tlo[7:0];
			endcase
		end
		set_alphabets(5'(fr), flo, fhi, 5'(tr), tlo, thi);
	endtask

	task automatic send_random_number();
		int unsigned pick;
		int unsigned ndig;
		pick = $urandom_range(99);
		if (pick < 75) begin
			case ($urandom_range(2))
				1: send_char(CH_PLUS, 1'b0);
				2: send_char(CH_MINUS, 1'b0);
				default: ;
			endcase
			// Now and then a long run of digits to walk up to and past the range limit.
			ndig = ($urandom_range(9) == 0) ? $urandom_range(34, 20) : $urandom_range(8, 1);
			for (int k = 0; k < ndig; k++)
				send_char(src_digit(), k == ndig - 1);
		end else if (pick < 90) begin
			ndig = $urandom_range(6, 1);
			for (int k = 0; k < ndig; k++)
				send_char($urandom_range(1) ? 8'($urandom_range(255, 0)) : src_digit(),
					k == ndig - 1);
		end else begin
			ndig = $urandom_range(3, 0);
			for (int k = 0; k < ndig; k++)
				send_char(src_digit(), 1'b0);
			send_char($urandom_range(1) ? CH_MINUS : CH_PLUS, ndig == 0);
			if (ndig != 0)
				send_char(src_digit(), 1'b1);
		end
	endtask

	task automatic test_alphabet_checks();
		logic [63:0] word;
		// Out of reset every alphabet word is zero.
		send_char(CH_NUL, 1'b1);
		set_alphabets(5'd1, HEX_LO, HEX_HI, 5'd10, HEX_LO, DEC_HI);
		send_text("1");
		set_alphabets(5'd0, HEX_LO, HEX_HI, 5'd10, HEX_LO, DEC_HI);
		send_text("1");
		set_alphabets(5'd31, HEX_LO, HEX_HI, 5'd10, HEX_LO, DEC_HI);
		send_text("Z");
		set_alphabets(5'd16, HEX_LO, HEX_HI, 5'd17, HEX_LO, HEX_HI);
		send_text("1");
		set_alphabets(5'd16, HEX_LO, HEX_HI, 5'd16, HEX_LO, 64'h0);
		send_text("1");
		word = HEX_LO;
		word[5*8 +: 8] = CH_PLUS;
		set_alphabets(5'd16, word, HEX_HI, 5'd10, HEX_LO, DEC_HI);
		send_text("1");
		word[5*8 +: 8] = CH_SPACE;
		set_alphabets(5'd16, word, HEX_HI, 5'd10, HEX_LO, 64'h0000_0000_0000_2D38);
		send_text("1");
		set_alphabets(5'd4, 64'h0000_0000_3032_3130, 64'h0, 5'd10, HEX_LO, DEC_HI);
		send_text("0");
		// Repeated symbols above the radix are harmless.
		set_alphabets(5'd2, 64'h0000_0000_3130_3130, 64'h0, 5'd2, BIN_LO, 64'h0);
		send_text("-11");
	endtask

	task automatic test_value_extremes();
		set_alphabets(5'd16, HEX_LO, HEX_HI, 5'd10, HEX_LO, DEC_HI);
		send_text("7FFFFFFF");
		send_text("F");
		set_alphabets(5'd16, HEX_LO, HEX_HI, 5'd2, BIN_LO, 64'h0);
		send_text("-80000000");
		send_text("80000000");
		send_text("-0");
		send_text("+");
		send_text("1G");
		send_text("3-");
		send_text("+-");
	endtask

	task automatic test_random_phase(int unsigned snd, int unsigned rcv, int unsigned n_chars);
		int unsigned goal;
		send_pct = snd;
		recv_pct = rcv;
		goal = sent_chars + n_chars;
		while (sent_chars < goal) begin
			random_config();
			repeat (4) send_random_number();
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_alphabet_checks();
		test_value_extremes();
		test_random_phase(11, 55, 40);
		test_random_phase(55, 11, 40);
		test_random_phase(0, 0, 40);
		wait_idle();
		if (fail_count == 0)
			$display("radix_string_converter_unit regression: pass");
		else
			$display("radix_string_converter_unit regression: fail");
		$finish;
	end

endmodule

>>> radix_string_converter_unit.f
rtl/core/rsc_pkg.sv
rtl/core/rsc_seq.sv
rtl/core/rsc_datapath.sv
rtl/core/radix_string_converter_unit.sv
rtl/core/rsc_checker.sv
sim/tb_top.sv
